// ===== design/srwagc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwagc_pkg
// Types, constants, microcode ROM and arithmetic helpers for the stereo
// moving-RMS gain control unit.
// ----------------------------------------------------------------------------
package srwagc_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_TARGET  = 2'd0,
		REG_ATTACK  = 2'd1,
		REG_RELEASE = 2'd2,
		REG_NOISE   = 2'd3
	} reg_idx_t;

	localparam logic [14:0] TARGET_RST  = 15'd16384;
	localparam logic [11:0] ATTACK_RST  = 12'd41;
	localparam logic [11:0] RELEASE_RST = 12'd4;
	localparam logic [14:0] NOISE_RST   = 15'd328;

	localparam logic [15:0] GAIN_UNITY      = 16'd4096;
	localparam logic [15:0] GAIN_LOW_LIMIT  = 16'd3686;
	localparam logic [15:0] GAIN_HIGH_LIMIT = 16'd4506;

	typedef logic [3:0] step_t;

	localparam step_t ST_SQ  = 4'd0;
	localparam step_t ST_NT  = 4'd1;
	localparam step_t ST_NW  = 4'd2;
	localparam step_t ST_TT  = 4'd3;
	localparam step_t ST_TW  = 4'd4;
	localparam step_t ST_GG  = 4'd5;
	localparam step_t ST_SL  = 4'd6;
	localparam step_t ST_SH  = 4'd7;
	localparam step_t ST_ACC = 4'd8;
	localparam step_t ST_SIG = 4'd9;
	localparam step_t ST_NLO = 4'd10;
	localparam step_t ST_NHI = 4'd11;
	localparam step_t ST_OL  = 4'd12;
	localparam step_t ST_OR  = 4'd13;
	localparam step_t ST_OUT = 4'd14;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_LL,
		MUL_NN,
		MUL_PW,
		MUL_TT,
		MUL_GG,
		MUL_SLP,
		MUL_SHG,
		MUL_LG,
		MUL_RG
	} mul_sel_t;

	typedef enum logic [3:0] {
		ALU_NOP,
		ALU_SQ,
		ALU_SUM,
		ALU_T,
		ALU_G2,
		ALU_ACC_LD,
		ALU_ACC_ADD,
		ALU_GAIN_SIG,
		ALU_GAIN_LOW,
		ALU_GAIN_HIGH,
		ALU_LSAT,
		ALU_OUT
	} alu_op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_BR_NOISE,
		SEQ_GOTO,
		SEQ_END
	} seq_op_t;

	typedef struct packed {
		mul_sel_t mul;
		alu_op_t  alu;
		seq_op_t  seq;
		step_t    target;
	} uword_t;

	typedef struct packed {
		mul_sel_t mul;
		alu_op_t  alu;
	} ctrl_t;

	typedef struct packed {
		logic noise;
		logic out_free;
	} status_t;

	// product of one step lands in the product register, used by the next
	function automatic uword_t ucode(input step_t step);
		unique case (step)
			ST_SQ:   ucode = '{mul: MUL_LL,   alu: ALU_NOP,       seq: SEQ_NEXT,     target: ST_SQ};
			ST_NT:   ucode = '{mul: MUL_NN,   alu: ALU_SQ,        seq: SEQ_NEXT,     target: ST_SQ};
			ST_NW:   ucode = '{mul: MUL_PW,   alu: ALU_SUM,       seq: SEQ_NEXT,     target: ST_SQ};
			ST_TT:   ucode = '{mul: MUL_TT,   alu: ALU_NOP,       seq: SEQ_BR_NOISE, target: ST_NLO};
			ST_TW:   ucode = '{mul: MUL_PW,   alu: ALU_NOP,       seq: SEQ_NEXT,     target: ST_SQ};
			ST_GG:   ucode = '{mul: MUL_GG,   alu: ALU_T,         seq: SEQ_NEXT,     target: ST_SQ};
			ST_SL:   ucode = '{mul: MUL_SLP,  alu: ALU_G2,        seq: SEQ_NEXT,     target: ST_SQ};
			ST_SH:   ucode = '{mul: MUL_SHG,  alu: ALU_ACC_LD,    seq: SEQ_NEXT,     target: ST_SQ};
			ST_ACC:  ucode = '{mul: MUL_NONE, alu: ALU_ACC_ADD,   seq: SEQ_NEXT,     target: ST_SQ};
			ST_SIG:  ucode = '{mul: MUL_NONE, alu: ALU_GAIN_SIG,  seq: SEQ_GOTO,     target: ST_OL};
			ST_NLO:  ucode = '{mul: MUL_NONE, alu: ALU_GAIN_LOW,  seq: SEQ_NEXT,     target: ST_SQ};
			ST_NHI:  ucode = '{mul: MUL_NONE, alu: ALU_GAIN_HIGH, seq: SEQ_NEXT,     target: ST_SQ};
			ST_OL:   ucode = '{mul: MUL_LG,   alu: ALU_NOP,       seq: SEQ_NEXT,     target: ST_SQ};
			ST_OR:   ucode = '{mul: MUL_RG,   alu: ALU_LSAT,      seq: SEQ_NEXT,     target: ST_SQ};
			// right product kept alive while the final load waits
			ST_OUT:  ucode = '{mul: MUL_RG,   alu: ALU_OUT,       seq: SEQ_END,      target: ST_SQ};
			default: ucode = '{mul: MUL_NONE, alu: ALU_NOP,       seq: SEQ_END,      target: ST_SQ};
		endcase
	endfunction

	function automatic logic [15:0] gain_add(input logic [15:0] g, input logic [11:0] d);
		logic [16:0] r;
		r = {1'b0, g} + {5'b0, d};
		gain_add = r[16] ? 16'hFFFF : r[15:0];
	endfunction

	function automatic logic [15:0] gain_sub(input logic [15:0] g, input logic [11:0] d);
		gain_sub = ({4'b0, d} > g) ? 16'd0 : g - {4'b0, d};
	endfunction

	// round half up, then clamp to 16 bits
	function automatic logic [15:0] sat_out(input logic signed [33:0] p);
		logic signed [33:0] r;
		logic signed [33:0] q;
		r = p + 34'sd2048;
		q = r >>> 12;
		if (q > 34'sd32767) begin
			sat_out = 16'h7FFF;
		end else if (q < -34'sd32768) begin
			sat_out = 16'h8000;
		end else begin
			sat_out = q[15:0];
		end
	endfunction

endpackage

// ===== design/srwagc_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwagc_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module srwagc_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  srwagc_pkg::status_t stat,
	output srwagc_pkg::ctrl_t   ctrl,
	output logic                busy
);

	logic               busy_q;
	srwagc_pkg::step_t  step_q;
	srwagc_pkg::uword_t uw;

	assign uw   = srwagc_pkg::ucode(step_q);
	assign busy = busy_q;

	// the final step holds until the output register is free
	always_comb begin
		ctrl.mul = srwagc_pkg::MUL_NONE;
		ctrl.alu = srwagc_pkg::ALU_NOP;
		if (busy_q) begin
			ctrl.mul = uw.mul;
			if (uw.seq != srwagc_pkg::SEQ_END || stat.out_free) begin
				ctrl.alu = uw.alu;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= srwagc_pkg::ST_SQ;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= srwagc_pkg::ST_SQ;
			end
		end else begin
			unique case (uw.seq)
				srwagc_pkg::SEQ_NEXT: begin
					step_q <= step_q + 4'd1;
				end
				srwagc_pkg::SEQ_BR_NOISE: begin
					step_q <= stat.noise ? uw.target : step_q + 4'd1;
				end
				srwagc_pkg::SEQ_GOTO: begin
					step_q <= uw.target;
				end
				srwagc_pkg::SEQ_END: begin
					if (stat.out_free) begin
						busy_q <= 1'b0;
					end
				end
			endcase
		end
	end

endmodule

// ===== design/stereo_rms_window_agc_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_rms_window_agc_unit
// Stereo gain control driven by the moving mean square of the left channel,
// run by a microcoded sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
// channel   direction  handshake          word
// input     in         in_valid/in_stall  left_in, right_in
// output    out        out_valid/out_stall left_out, right_out
// config    in         APB psel/penable   target, attack, release, noise
//
// A word runs steps SQ, NT, NW, TT, then NLO, NHI (noise path) or TW, GG, SL,
// SH, ACC, SIG (signal path), then OL, OR, OUT to a loaded output, on the
// single multiplier; the next word is only taken once that word is through.
// in_stall is high while the sequencer runs; a word waiting at the output
// does not block the next input, only the final load of the next result.
// The sample ring needs no clearing after reset: a wrap flag marks it filled.
// ----------------------------------------------------------------------------
module stereo_rms_window_agc_unit #(
	parameter int WINDOW = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [15:0]            left_in,
	input  logic signed [15:0]            right_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            left_out,
	output logic signed [15:0]            right_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [srwagc_pkg::ADDR_W-1:0] paddr,
	input  logic [srwagc_pkg::DATA_W-1:0] pwdata,
	output logic [srwagc_pkg::DATA_W-1:0] prdata,
	output logic                          pready
);

	localparam int PW    = $clog2(WINDOW);
	localparam int SW    = 31 + PW;
	localparam int ACC_W = SW + 32;

	logic [14:0] target_q;
	logic [11:0] attack_q;
	logic [11:0] release_q;
	logic [14:0] noise_q;

	logic                 busy;
	logic                 in_acc;
	srwagc_pkg::ctrl_t    ctrl;
	srwagc_pkg::status_t  stat;
	srwagc_pkg::reg_idx_t reg_idx;

	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic [30:0]        ring_mem [WINDOW];
	logic [30:0]        rd_q;
	logic [30:0]        old_sq;
	logic [PW-1:0]      pos_q;
	logic               full_q;
	logic [30:0]        sq_q;
	logic [SW-1:0]      s_q;
	logic [63:0]        s_ext;
	logic [SW-1:0]      t_q;
	logic [31:0]        g2_q;
	logic [ACC_W-1:0]   acc_q;
	logic               above;
	logic [15:0]        gain_q;
	logic [15:0]        lsat_q;
	logic               out_valid_q;
	logic [15:0]        lo_q;
	logic [15:0]        ro_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic [63:0]        prod_q;

	assign pready  = 1'b1;
	assign reg_idx = srwagc_pkg::reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (reg_idx)
			srwagc_pkg::REG_TARGET:  prdata = 32'(target_q);
			srwagc_pkg::REG_ATTACK:  prdata = 32'(attack_q);
			srwagc_pkg::REG_RELEASE: prdata = 32'(release_q);
			srwagc_pkg::REG_NOISE:   prdata = 32'(noise_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= srwagc_pkg::TARGET_RST;
			attack_q  <= srwagc_pkg::ATTACK_RST;
			release_q <= srwagc_pkg::RELEASE_RST;
			noise_q   <= srwagc_pkg::NOISE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				srwagc_pkg::REG_TARGET:  target_q  <= pwdata[14:0];
				srwagc_pkg::REG_ATTACK:  attack_q  <= pwdata[11:0];
				srwagc_pkg::REG_RELEASE: release_q <= pwdata[11:0];
				srwagc_pkg::REG_NOISE:   noise_q   <= pwdata[14:0];
			endcase
		end
	end

	assign in_stall  = busy;
	assign in_acc    = in_valid && !busy;
	assign out_valid = out_valid_q;
	assign left_out  = lo_q;
	assign right_out = ro_q;

	assign s_ext         = 64'(s_q);
	assign stat.noise    = s_ext < prod_q;
	assign stat.out_free = !out_valid_q || !out_stall;
	assign above         = acc_q > (ACC_W'(t_q) << 24);
	assign old_sq        = full_q ? rd_q : 31'd0;

	srwagc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctrl.mul)
			srwagc_pkg::MUL_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			srwagc_pkg::MUL_LL: begin
				mul_a = 33'(left_q);
				mul_b = 33'(left_q);
			end
			srwagc_pkg::MUL_NN: begin
				mul_a = 33'(noise_q);
				mul_b = 33'(noise_q);
			end
			srwagc_pkg::MUL_PW: begin
				mul_a = 33'(prod_q[31:0]);
				mul_b = 33'(WINDOW);
			end
			srwagc_pkg::MUL_TT: begin
				mul_a = 33'(target_q);
				mul_b = 33'(target_q);
			end
			srwagc_pkg::MUL_GG: begin
				mul_a = 33'(gain_q);
				mul_b = 33'(gain_q);
			end
			srwagc_pkg::MUL_SLP: begin
				mul_a = 33'(s_ext[31:0]);
				mul_b = 33'(prod_q[31:0]);
			end
			srwagc_pkg::MUL_SHG: begin
				mul_a = 33'(s_ext[63:32]);
				mul_b = 33'(g2_q);
			end
			srwagc_pkg::MUL_LG: begin
				mul_a = 33'(left_q);
				mul_b = 33'(gain_q);
			end
			srwagc_pkg::MUL_RG: begin
				mul_a = 33'(right_q);
				mul_b = 33'(gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// payload, ring storage and datapath result registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p[63:0];
		if (in_acc) begin
			left_q  <= left_in;
			right_q <= right_in;
			rd_q    <= ring_mem[pos_q];
		end
		if (ctrl.alu == srwagc_pkg::ALU_SUM) begin
			ring_mem[pos_q] <= sq_q;
		end
		unique case (ctrl.alu)
			srwagc_pkg::ALU_SQ:      sq_q   <= prod_q[30:0];
			srwagc_pkg::ALU_T:       t_q    <= prod_q[SW-1:0];
			srwagc_pkg::ALU_G2:      g2_q   <= prod_q[31:0];
			srwagc_pkg::ALU_ACC_LD:  acc_q  <= ACC_W'(prod_q);
			srwagc_pkg::ALU_ACC_ADD: acc_q  <= acc_q + (ACC_W'(prod_q) << 32);
			srwagc_pkg::ALU_LSAT:    lsat_q <= srwagc_pkg::sat_out(prod_q[33:0]);
			srwagc_pkg::ALU_OUT: begin
				lo_q <= lsat_q;
				ro_q <= srwagc_pkg::sat_out(prod_q[33:0]);
			end
			default: begin
			end
		endcase
	end

	// detector, gain and output-valid state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			full_q      <= 1'b0;
			s_q         <= '0;
			gain_q      <= srwagc_pkg::GAIN_UNITY;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.alu == srwagc_pkg::ALU_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctrl.alu)
				srwagc_pkg::ALU_SUM: begin
					s_q <= s_q - SW'(old_sq) + SW'(sq_q);
					if (pos_q == PW'(WINDOW - 1)) begin
						pos_q  <= '0;
						full_q <= 1'b1;
					end else begin
						pos_q <= pos_q + PW'(1);
					end
				end
				srwagc_pkg::ALU_GAIN_SIG: begin
					gain_q <= above ? srwagc_pkg::gain_sub(gain_q, attack_q)
					                : srwagc_pkg::gain_add(gain_q, release_q);
				end
				srwagc_pkg::ALU_GAIN_LOW: begin
					if (gain_q <= srwagc_pkg::GAIN_LOW_LIMIT) begin
						gain_q <= srwagc_pkg::gain_add(gain_q, release_q);
					end
				end
				srwagc_pkg::ALU_GAIN_HIGH: begin
					if (gain_q >= srwagc_pkg::GAIN_HIGH_LIMIT) begin
						gain_q <= srwagc_pkg::gain_sub(gain_q, release_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
